/* src/hmp_pkg.sv */
// Shared types and constants for the hash message padder.
`timescale 1ns / 1ps

package hmp_pkg;

  // Input operation codes
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_BLOCK_MODE        = 1'b0,
    CFG_LENGTH_BIG_ENDIAN = 1'b1
  } cfg_index_t;

  // Padder sequencing
  typedef enum logic {
    ST_DATA = 1'b0,
    ST_PAD  = 1'b1
  } pad_state_t;

  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam logic [2:0] WORD_LAST_BYTE = 3'd7;
  // First word of the 16-byte length field in 128-byte blocks
  localparam logic [3:0] LEN_HI_WORD    = 4'd14;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] block_word;
    logic        block_end;
    logic        message_end;
  } out_item_t;

  // Reverse the byte order of a 64-bit word
  function automatic logic [63:0] byte_swap64(input logic [63:0] w);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = w[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

/* src/hash_message_padder.sv */
// Top level of the hash message padder: byte packing, padding and length insertion.
// A completed word appears in the result register in the cycle after its last
// byte (or the end-of-message transaction) is accepted. Throughput: one message byte
// per cycle unless stalled. An end-of-message transaction emits 2 to 18 words,
// one per cycle unless result_stall is high; item input stalls while they go out.
// Reset (rst, synchronous): counters, word assembly and configuration clear;
// the block takes a new message at once.
`timescale 1ns / 1ps

module hash_message_padder (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  hmp_pkg::cfg_index_t   cfg_index,
  input  logic                  cfg_data,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  hmp_pkg::in_item_t     item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output hmp_pkg::out_item_t    result
);
  import hmp_pkg::*;

  // Configuration
  logic block_mode;
  logic length_big_endian;

  // Message state
  pad_state_t  state, state_next;
  logic [60:0] byte_count, byte_count_next;
  logic [55:0] asm_word, asm_word_next;
  logic [2:0]  byte_in_word, byte_in_word_next;
  logic [3:0]  word_in_block, word_in_block_next;
  logic        skip_wrap, skip_wrap_next;

  // Datapath
  logic        out_free;
  logic        item_fire;
  logic        out_load;
  out_item_t   out_next;
  logic [3:0]  word_pos;
  logic [3:0]  field_word;
  logic        word_last;
  logic [3:0]  pos_next;
  logic        is_len;
  logic [63:0] len_bits;
  logic [63:0] len_word;
  logic [63:0] pad_first;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_mode        <= 1'b0;
      length_big_endian <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_MODE:        block_mode        <= cfg_data;
        CFG_LENGTH_BIG_ENDIAN: length_big_endian <= cfg_data;
        default:               block_mode        <= block_mode;
      endcase
    end
  end

  // Position within the block, taken modulo the current block size
  assign field_word = {block_mode, 3'b111};
  assign word_pos   = word_in_block & field_word;
  assign word_last  = (word_pos == field_word);
  assign pos_next   = word_last ? 4'd0 : word_pos + 4'd1;

  // Length field word and first padding word
  assign len_bits  = {byte_count, 3'b000};
  assign len_word  = length_big_endian ? len_bits : byte_swap64(len_bits);
  assign pad_first = {asm_word, PAD_MARK} << {~byte_in_word, 3'b000};
  assign is_len    = word_last && !skip_wrap;

  // Handshake
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_DATA) ||
                      (!out_free && ((item.operation == OP_END) ||
                                     (byte_in_word == WORD_LAST_BYTE)));
  assign item_fire  = item_valid && !item_stall;

  // Next state and result word
  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    asm_word_next      = asm_word;
    byte_in_word_next  = byte_in_word;
    word_in_block_next = word_in_block;
    skip_wrap_next     = skip_wrap;
    out_load           = 1'b0;
    out_next           = '0;

    unique case (state)
      ST_DATA: begin
        if (item_fire) begin
          if (item.operation == OP_DATA) begin
            byte_count_next = byte_count + 61'd1;
            if (byte_in_word == WORD_LAST_BYTE) begin
              out_load             = 1'b1;
              out_next.block_word  = {asm_word, item.data_byte};
              out_next.block_end   = word_last;
              asm_word_next        = '0;
              byte_in_word_next    = '0;
              word_in_block_next   = pos_next;
            end else begin
              asm_word_next     = {asm_word[47:0], item.data_byte};
              byte_in_word_next = byte_in_word + 3'd1;
            end
          end else begin
            // close the partial word with the pad mark, then emit the tail
            out_load            = 1'b1;
            out_next.block_word = pad_first;
            out_next.block_end  = word_last;
            asm_word_next       = '0;
            byte_in_word_next   = '0;
            word_in_block_next  = pos_next;
            skip_wrap_next      = block_mode && (word_pos == LEN_HI_WORD);
            state_next          = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.block_word  = is_len ? len_word : 64'd0;
          out_next.block_end   = word_last;
          out_next.message_end = is_len;
          if (is_len) begin
            byte_count_next    = '0;
            word_in_block_next = '0;
            skip_wrap_next     = 1'b0;
            state_next         = ST_DATA;
          end else begin
            word_in_block_next = pos_next;
            if (word_last) begin
              skip_wrap_next = 1'b0;
            end
          end
        end
      end
      default: state_next = ST_DATA;
    endcase
  end

  // Hold message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_DATA;
      byte_count    <= '0;
      asm_word      <= '0;
      byte_in_word  <= '0;
      word_in_block <= '0;
      skip_wrap     <= 1'b0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      asm_word      <= asm_word_next;
      byte_in_word  <= byte_in_word_next;
      word_in_block <= word_in_block_next;
      skip_wrap     <= skip_wrap_next;
    end
  end

  // Result register: load a new word or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_next;
    end
  end

  // Checks
  a_msg_end_is_block_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.message_end |-> result.block_end)
    else $error("message end without block end");

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD |-> item_stall)
    else $error("item accepted during padding");

  a_clear_after_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD && out_load && is_len |=>
      state == ST_DATA && byte_count == 61'd0 && byte_in_word == 3'd0 &&
      word_in_block == 4'd0)
    else $error("state not cleared after length word");

  a_skip_only_in_pad: assert property (@(posedge clk) disable iff (rst)
    skip_wrap |-> state == ST_PAD)
    else $error("wrap flag set outside padding");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result overwritten while stalled");

endmodule

/* sim/tb_hash_message_padder.sv */
// Self-checking testbench for the hash message padder.
`timescale 1ns / 1ps

module tb_hash_message_padder;
  import hmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_BLOCK_MODE;
  logic cfg_data = 1'b0;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;

  // Idle and stall rates in percent, set per test
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  // Hold-off requests; the receiver process counts the cycles itself
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int idle_cycles = 0;

  // Padder prediction state
  logic mode_cfg = 1'b0;
  logic big_endian_cfg = 1'b0;
  logic [60:0] byte_count = '0;
  logic [63:0] word_acc = '0;
  logic [2:0] byte_idx = '0;
  logic [3:0] word_idx = '0;
  out_item_t padded_words_q[$];
  out_item_t want;

  hash_message_padder u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #4 clk = ~clk;

  // Word position wraps at the block size of the current mode
  function automatic logic [3:0] word_pos();
    return mode_cfg ? word_idx : {1'b0, word_idx[2:0]};
  endfunction

  // Shift one byte into the word; queue the word once it is full
  function automatic void pack_byte(input logic [7:0] b);
    logic [3:0] pos;
    logic last;
    out_item_t w;
    word_acc = {word_acc[55:0], b};
    if (byte_idx == WORD_LAST_BYTE) begin
      pos = word_pos();
      last = (pos == (mode_cfg ? 4'd15 : 4'd7));
      w.block_word = word_acc;
      w.block_end = last;
      w.message_end = 1'b0;
      padded_words_q.push_back(w);
      word_acc = '0;
      byte_idx = '0;
      word_idx = last ? 4'd0 : pos + 4'd1;
    end else begin
      byte_idx = byte_idx + 3'd1;
    end
  endfunction

  // Update the expected words for one accepted transaction
  function automatic void predict_transaction(input op_t op, input logic [7:0] b);
    logic [63:0] bit_len;
    logic [6:0] len_start;
    out_item_t last_w;
    if (op == OP_DATA) begin
      pack_byte(b);
      byte_count = byte_count + 61'd1;
    end else begin
      bit_len = {byte_count, 3'b000};
      len_start = mode_cfg ? 7'd112 : 7'd56;
      pack_byte(PAD_MARK);
      while ({word_pos(), byte_idx} != len_start) pack_byte(8'h00);
      if (mode_cfg) repeat (8) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) begin
        pack_byte(big_endian_cfg ? bit_len[8*(7-i) +: 8] : bit_len[8*i +: 8]);
      end
      last_w = padded_words_q.pop_back();
      last_w.message_end = 1'b1;
      padded_words_q.push_back(last_w);
      byte_count = '0;
      word_acc = '0;
      byte_idx = '0;
      word_idx = '0;
    end
  endfunction

  // Check each accepted word against the oldest expectation, then predict
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (padded_words_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual %h end %b msg %b",
                   $time, result.block_word, result.block_end, result.message_end);
        end else begin
          want = padded_words_q.pop_front();
          if (result.block_word !== want.block_word) begin
            errors++;
            $display("%0t: block_word mismatch: expected %h actual %h",
                     $time, want.block_word, result.block_word);
          end
          if (result.block_end !== want.block_end) begin
            errors++;
            $display("%0t: block_end mismatch: expected %b actual %b",
                     $time, want.block_end, result.block_end);
          end
          if (result.message_end !== want.message_end) begin
            errors++;
            $display("%0t: message_end mismatch: expected %b actual %b",
                     $time, want.message_end, result.message_end);
          end
        end
      end
      if (item_valid && !item_stall) predict_transaction(item.operation, item.data_byte);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen = hold_off_reqs;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words pending", $time, padded_words_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic offer_item(input op_t op, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= '{operation: op, data_byte: b};
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
    offer_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_until_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (padded_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_index_t idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BLOCK_MODE: mode_cfg = val;
      CFG_LENGTH_BIG_ENDIAN: big_endian_cfg = val;
      default: ;
    endcase
  endtask

  // Mostly short messages, now and then one near the length-field boundary
  function automatic int pick_length();
    int base;
    int k;
    base = mode_cfg ? 112 : 56;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 3))
        0: return base - 1;
        1: return base;
        2: return base + 7;
        default: return base + 8;
      endcase
    end else if (k == 1) begin
      return 0;
    end
    return $urandom_range(1, 24);
  endfunction

  // Reset defaults: 64-byte blocks, little-endian length
  task automatic test_reset_defaults();
    offer_item(OP_END, 8'hFF);
    offer_item(OP_DATA, 8'h00);
    offer_item(OP_DATA, 8'hFF);
    offer_item(OP_DATA, 8'h5A);
    offer_item(OP_END, 8'h33);
    wait_until_drained();
  endtask

  // Both register values in the three combinations other than the reset defaults
  task automatic test_config_extremes();
    write_config(CFG_BLOCK_MODE, 1'b1);
    write_config(CFG_LENGTH_BIG_ENDIAN, 1'b1);
    offer_item(OP_END, 8'hFF);
    offer_item(OP_DATA, 8'h80);
    offer_item(OP_DATA, 8'h01);
    offer_item(OP_END, 8'h00);
    wait_until_drained();
    write_config(CFG_BLOCK_MODE, 1'b0);
    offer_item(OP_DATA, 8'hFE);
    offer_item(OP_DATA, 8'h7F);
    offer_item(OP_END, 8'hAA);
    wait_until_drained();
    write_config(CFG_BLOCK_MODE, 1'b1);
    write_config(CFG_LENGTH_BIG_ENDIAN, 1'b0);
    offer_item(OP_DATA, 8'h00);
    offer_item(OP_END, 8'h55);
    wait_until_drained();
  endtask

  // Switch block size with a message half done, both ways
  task automatic test_mode_switch_mid_message();
    write_config(CFG_BLOCK_MODE, 1'b1);
    for (int i = 0; i < 72; i++) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
    wait_until_drained();
    write_config(CFG_BLOCK_MODE, 1'b0);
    send_message(5);
    wait_until_drained();
    for (int i = 0; i < 20; i++) offer_item(OP_DATA, 8'($urandom_range(0, 255)));
    wait_until_drained();
    write_config(CFG_BLOCK_MODE, 1'b1);
    offer_item(OP_END, 8'($urandom_range(0, 255)));
    wait_until_drained();
  endtask

  // Hold the output off long enough that the input stalls
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    @(negedge clk);
    hold_off_reqs = hold_off_reqs + 1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(0, 10));
    wait_until_drained();
  endtask

  // Random messages over all idle patterns and register settings
  task automatic test_random_traffic();
    int sent;
    int len;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      write_config(CFG_BLOCK_MODE, p == 1 || p == 3);
      write_config(CFG_LENGTH_BIG_ENDIAN, p == 1 || p == 2);
      sent = 0;
      while (sent < 15) begin
        len = pick_length();
        send_message(len);
        sent = sent + len + 1;
      end
      wait_until_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_config_extremes();
    test_mode_switch_mid_message();
    test_output_backpressure();
    test_random_traffic();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && padded_words_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d words never seen",
               $time, errors, padded_words_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
